/* design/pbbr_pkg.sv */
// ============================================================================
// pbbr_pkg: shared types and constants for the particle box boundary block
// Holds the default coordinate width, damping format, register indexes and
// the control group that travels with each particle through the pipeline.
// ============================================================================
package pbbr_pkg;

  localparam int PBBR_COORD_BITS = 20;
  localparam int PBBR_DAMP_BITS  = 16;
  localparam int PBBR_IDX_BITS   = 3;

  // Register indexes on the configuration port.
  localparam logic [PBBR_IDX_BITS-1:0] PBBR_REG_LOW_CORNER  = 3'd0;
  localparam logic [PBBR_IDX_BITS-1:0] PBBR_REG_HIGH_CORNER = 3'd1;
  localparam logic [PBBR_IDX_BITS-1:0] PBBR_REG_MARGIN      = 3'd2;
  localparam logic [PBBR_IDX_BITS-1:0] PBBR_REG_ROOF_OPEN   = 3'd3;
  localparam logic [PBBR_IDX_BITS-1:0] PBBR_REG_DIST_DAMP   = 3'd4;
  localparam logic [PBBR_IDX_BITS-1:0] PBBR_REG_ENERGY_DAMP = 3'd5;

  // Reset values of the registers that do not clear to zero.
  localparam int PBBR_MARGIN_RST      = 4096;
  localparam int PBBR_ENERGY_DAMP_RST = 32768;

  // Control group that rides along with the payload.
  // vld: a particle occupies the stage. en: faces may still correct it
  // (cleared when the particle leaves through the roof). hit: a face fired.
  typedef struct packed {
    logic vld;
    logic en;
    logic hit;
  } pbbr_ctl_t;

endpackage

/* design/pbbr_face.sv */
// ============================================================================
// pbbr_face: one face check with push-back and reflection, three stages
// Stage A finds the penetration depth and decides the hit, stage B forms the
// push-back and reflection products, stage C rounds, subtracts and saturates.
// ============================================================================
module pbbr_face
  import pbbr_pkg::*;
#(
  parameter int COORD_BITS = PBBR_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            high_face,
  input  logic                            refl_pos,
  input  logic        [COORD_BITS-1:0]    bound,
  input  logic        [COORD_BITS-2:0]    margin,
  input  logic        [PBBR_DAMP_BITS-1:0] dist_damp,
  input  logic        [PBBR_DAMP_BITS-1:0] energy_damp,
  input  pbbr_ctl_t                       ctl_in,
  input  logic signed [COORD_BITS-1:0]    pos_in,
  input  logic signed [COORD_BITS-1:0]    vel_in,
  output pbbr_ctl_t                       ctl_out,
  output logic signed [COORD_BITS-1:0]    pos_out,
  output logic signed [COORD_BITS-1:0]    vel_out
);

  localparam int CB = COORD_BITS;
  localparam int DB = PBBR_DAMP_BITS;
  localparam int DW = CB + 1;          // depth
  localparam int EW = CB + 2;          // depth compared against margin
  localparam int PW = DW + DB + 2;     // depth times push-back factor
  localparam int VW = CB + DB + 1;     // velocity times energy factor
  localparam int SW = CB + 3;          // value before saturation

  localparam logic signed [PW-1:0] RND_P = PW'(1) << (DB - 1);
  localparam logic signed [VW:0]   RND_V = (VW + 1)'(1) << (DB - 1);
  localparam logic signed [SW-1:0] SAT_MAX = SW'((1 << (CB - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(1 << (CB - 1));

  function automatic logic signed [CB-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [CB-1:0] res;
    if (x > SAT_MAX) begin
      res = SAT_MAX[CB-1:0];
    end else if (x < SAT_MIN) begin
      res = SAT_MIN[CB-1:0];
    end else begin
      res = x[CB-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stage A: depth and hit decision
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] depth;
  logic signed [EW-1:0] depth_ext;
  logic signed [EW-1:0] margin_ext;
  logic signed [EW-1:0] depth_plus_m;
  logic                 outside_hi;
  logic                 outside_lo;
  logic                 near_hi;
  logic                 near_lo;
  logic                 vel_is_pos;
  logic                 vel_is_neg;
  logic                 hit_nxt;
  logic                 refl_nxt;

  assign depth        = $signed({pos_in[CB-1], pos_in}) - $signed({bound[CB-1], bound});
  assign depth_ext    = $signed({depth[DW-1], depth});
  assign margin_ext   = $signed({3'b000, margin});
  assign depth_plus_m = depth_ext + margin_ext;
  assign outside_hi   = !depth[DW-1] && (depth != '0);
  assign outside_lo   = depth[DW-1];
  assign near_hi      = depth_ext < margin_ext;
  assign near_lo      = !depth_plus_m[EW-1] && (depth_plus_m != '0);
  assign vel_is_pos   = !vel_in[CB-1] && (vel_in != '0);
  assign vel_is_neg   = vel_in[CB-1];

  assign hit_nxt  = ctl_in.vld && ctl_in.en &&
                    (high_face ? (outside_hi && near_hi) : (outside_lo && near_lo));
  assign refl_nxt = hit_nxt && (refl_pos ? vel_is_pos : vel_is_neg);

  pbbr_ctl_t            ctl_a_r;
  logic                 hit_a_r;
  logic                 refl_a_r;
  logic signed [DW-1:0] depth_a_r;
  logic signed [CB-1:0] pos_a_r;
  logic signed [CB-1:0] vel_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r  <= '0;
      hit_a_r  <= 1'b0;
      refl_a_r <= 1'b0;
    end else begin
      ctl_a_r  <= ctl_in;
      hit_a_r  <= hit_nxt;
      refl_a_r <= refl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    depth_a_r <= depth;
    pos_a_r   <= pos_in;
    vel_a_r   <= vel_in;
  end

  // --------------------------------------------------------------------------
  // Stage B: products
  // --------------------------------------------------------------------------
  logic signed [DB+1:0] push_fac;
  logic signed [DB:0]   keep_fac;
  logic signed [PW-1:0] push_prod_nxt;
  logic signed [VW-1:0] vel_prod_nxt;

  // Push-back factor is one plus the damping fraction, Q1.16.
  assign push_fac      = $signed({2'b01, dist_damp});
  assign keep_fac      = $signed({1'b0, energy_damp});
  assign push_prod_nxt = depth_a_r * push_fac;
  assign vel_prod_nxt  = vel_a_r * keep_fac;

  pbbr_ctl_t            ctl_b_r;
  logic                 hit_b_r;
  logic                 refl_b_r;
  logic signed [PW-1:0] push_prod_b_r;
  logic signed [VW-1:0] vel_prod_b_r;
  logic signed [CB-1:0] pos_b_r;
  logic signed [CB-1:0] vel_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r  <= '0;
      hit_b_r  <= 1'b0;
      refl_b_r <= 1'b0;
    end else begin
      ctl_b_r  <= ctl_a_r;
      hit_b_r  <= hit_a_r;
      refl_b_r <= refl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    push_prod_b_r <= push_prod_nxt;
    vel_prod_b_r  <= vel_prod_nxt;
    pos_b_r       <= pos_a_r;
    vel_b_r       <= vel_a_r;
  end

  // --------------------------------------------------------------------------
  // Stage C: round half up, apply and saturate
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] push_sum;
  logic signed [SW-1:0] corr;
  logic signed [SW-1:0] pos_full;
  logic signed [VW:0]   vel_neg;
  logic signed [VW:0]   vel_sum;
  logic signed [CB+1:0] vel_rnd;
  logic signed [SW-1:0] vel_full;
  pbbr_ctl_t            ctl_nxt;
  logic signed [CB-1:0] pos_nxt;
  logic signed [CB-1:0] vel_nxt;

  assign push_sum = push_prod_b_r + RND_P;
  assign corr     = $signed(push_sum[PW-1:DB]);
  assign pos_full = $signed({{3{pos_b_r[CB-1]}}, pos_b_r}) - corr;
  assign vel_neg  = -$signed({vel_prod_b_r[VW-1], vel_prod_b_r});
  assign vel_sum  = vel_neg + RND_V;
  assign vel_rnd  = $signed(vel_sum[VW:DB]);
  assign vel_full = $signed({vel_rnd[CB+1], vel_rnd});

  always_comb begin
    ctl_nxt     = ctl_b_r;
    ctl_nxt.hit = ctl_b_r.hit || hit_b_r;
    pos_nxt     = hit_b_r ? sat(pos_full) : pos_b_r;
    vel_nxt     = refl_b_r ? sat(vel_full) : vel_b_r;
  end

  pbbr_ctl_t            ctl_c_r;
  logic signed [CB-1:0] pos_c_r;
  logic signed [CB-1:0] vel_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
    end else begin
      ctl_c_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_c_r <= pos_nxt;
    vel_c_r <= vel_nxt;
  end

  assign ctl_out = ctl_c_r;
  assign pos_out = pos_c_r;
  assign vel_out = vel_c_r;

endmodule

/* design/particle_box_boundary_response.sv */
// ============================================================================
// particle_box_boundary_response: damped reflection against an axis box
// Corrects one particle per cycle against the six faces of a box: each axis
// runs its two faces in order through a chain of two three-stage face units.
// ============================================================================
// out_valid strobes a result after the entry stage and both face units.
// Throughput: one particle per cycle; busy is low in every cycle but the first.
// The rate is set by the six face units, each pipelined over three stages.
// Reset clears all valid bits and loads the register defaults; busy is high
// for the first cycle after reset. The receiver cannot stall the results.
module particle_box_boundary_response
  import pbbr_pkg::*;
#(
  parameter int COORD_BITS = PBBR_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic signed [COORD_BITS-1:0]  in_pos_z,
  input  logic signed [COORD_BITS-1:0]  in_vel_x,
  input  logic signed [COORD_BITS-1:0]  in_vel_y,
  input  logic signed [COORD_BITS-1:0]  in_vel_z,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  out_new_pos_x,
  output logic signed [COORD_BITS-1:0]  out_new_pos_y,
  output logic signed [COORD_BITS-1:0]  out_new_pos_z,
  output logic signed [COORD_BITS-1:0]  out_new_vel_x,
  output logic signed [COORD_BITS-1:0]  out_new_vel_y,
  output logic signed [COORD_BITS-1:0]  out_new_vel_z,
  output logic                          out_collided,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [PBBR_IDX_BITS-1:0]      cfg_index,
  input  logic [3*COORD_BITS-1:0]       cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int DB = PBBR_DAMP_BITS;
  localparam int EW = CB + 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [3*CB-1:0] low_r;
  logic [3*CB-1:0] high_r;
  logic [CB-2:0]   margin_r;
  logic            roof_open_r;
  logic [DB-1:0]   dist_damp_r;
  logic [DB-1:0]   energy_damp_r;
  logic            busy_r;
  logic            cfg_write;

  assign cfg_ready = !busy_r;
  assign busy      = busy_r;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r         <= '0;
      high_r        <= '0;
      margin_r      <= (CB - 1)'(PBBR_MARGIN_RST);
      roof_open_r   <= 1'b0;
      dist_damp_r   <= '0;
      energy_damp_r <= DB'(PBBR_ENERGY_DAMP_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        PBBR_REG_LOW_CORNER:  low_r         <= cfg_data;
        PBBR_REG_HIGH_CORNER: high_r        <= cfg_data;
        PBBR_REG_MARGIN:      margin_r      <= cfg_data[CB-2:0];
        PBBR_REG_ROOF_OPEN:   roof_open_r   <= cfg_data[0];
        PBBR_REG_DIST_DAMP:   dist_damp_r   <= cfg_data[DB-1:0];
        PBBR_REG_ENERGY_DAMP: energy_damp_r <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  logic [CB-1:0] low_x, low_y, low_z, high_x, high_y, high_z;

  assign low_x  = low_r[CB-1:0];
  assign low_y  = low_r[2*CB-1:CB];
  assign low_z  = low_r[3*CB-1:2*CB];
  assign high_x = high_r[CB-1:0];
  assign high_y = high_r[2*CB-1:CB];
  assign high_z = high_r[3*CB-1:2*CB];

  // --------------------------------------------------------------------------
  // Entry stage: a particle above the roof that is not caught by it leaves
  // the box untouched, so every face is disabled for it.
  // --------------------------------------------------------------------------
  logic                 accept;
  logic signed [EW-1:0] roof_depth;
  logic signed [EW-1:0] margin_ext;
  logic                 above_roof;
  logic                 pass_through;
  pbbr_ctl_t            ctl_nxt;

  assign accept       = start && !busy_r;
  assign roof_depth   = $signed({{2{in_pos_y[CB-1]}}, in_pos_y}) -
                        $signed({{2{high_y[CB-1]}}, high_y});
  assign margin_ext   = $signed({3'b000, margin_r});
  assign above_roof   = !roof_depth[EW-1] && (roof_depth != '0);
  assign pass_through = above_roof && (roof_open_r || !(roof_depth < margin_ext));

  always_comb begin
    ctl_nxt.vld = accept;
    ctl_nxt.en  = !pass_through;
    ctl_nxt.hit = 1'b0;
  end

  pbbr_ctl_t            ctl_s0_r;
  logic signed [CB-1:0] pos_x_s0_r, pos_y_s0_r, pos_z_s0_r;
  logic signed [CB-1:0] vel_x_s0_r, vel_y_s0_r, vel_z_s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s0_r <= '0;
    end else begin
      ctl_s0_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_s0_r <= in_pos_x;
    pos_y_s0_r <= in_pos_y;
    pos_z_s0_r <= in_pos_z;
    vel_x_s0_r <= in_vel_x;
    vel_y_s0_r <= in_vel_y;
    vel_z_s0_r <= in_vel_z;
  end

  // --------------------------------------------------------------------------
  // Face chains, one per axis, in the order the faces are checked.
  // --------------------------------------------------------------------------
  pbbr_ctl_t            ctl_y1, ctl_y2, ctl_x1, ctl_x2, ctl_z1, ctl_z2;
  logic signed [CB-1:0] pos_y1, vel_y1, pos_y2, vel_y2;
  logic signed [CB-1:0] pos_x1, vel_x1, pos_x2, vel_x2;
  logic signed [CB-1:0] pos_z1, vel_z1, pos_z2, vel_z2;

  // Roof: above the high y face, reflects upward motion.
  pbbr_face #(.COORD_BITS(CB)) u_roof (
    .clk(clk), .rst_n(rst_n), .high_face(1'b1), .refl_pos(1'b1),
    .bound(high_y), .margin(margin_r),
    .dist_damp(dist_damp_r), .energy_damp(energy_damp_r),
    .ctl_in(ctl_s0_r), .pos_in(pos_y_s0_r), .vel_in(vel_y_s0_r),
    .ctl_out(ctl_y1), .pos_out(pos_y1), .vel_out(vel_y1)
  );

  pbbr_face #(.COORD_BITS(CB)) u_bottom (
    .clk(clk), .rst_n(rst_n), .high_face(1'b0), .refl_pos(1'b0),
    .bound(low_y), .margin(margin_r),
    .dist_damp(dist_damp_r), .energy_damp(energy_damp_r),
    .ctl_in(ctl_y1), .pos_in(pos_y1), .vel_in(vel_y1),
    .ctl_out(ctl_y2), .pos_out(pos_y2), .vel_out(vel_y2)
  );

  pbbr_face #(.COORD_BITS(CB)) u_right (
    .clk(clk), .rst_n(rst_n), .high_face(1'b1), .refl_pos(1'b1),
    .bound(high_x), .margin(margin_r),
    .dist_damp(dist_damp_r), .energy_damp(energy_damp_r),
    .ctl_in(ctl_s0_r), .pos_in(pos_x_s0_r), .vel_in(vel_x_s0_r),
    .ctl_out(ctl_x1), .pos_out(pos_x1), .vel_out(vel_x1)
  );

  pbbr_face #(.COORD_BITS(CB)) u_left (
    .clk(clk), .rst_n(rst_n), .high_face(1'b0), .refl_pos(1'b0),
    .bound(low_x), .margin(margin_r),
    .dist_damp(dist_damp_r), .energy_damp(energy_damp_r),
    .ctl_in(ctl_x1), .pos_in(pos_x1), .vel_in(vel_x1),
    .ctl_out(ctl_x2), .pos_out(pos_x2), .vel_out(vel_x2)
  );

  // The z faces keep their velocity tests swapped: the close face reflects
  // only motion toward +z, the far face only motion toward -z.
  pbbr_face #(.COORD_BITS(CB)) u_close (
    .clk(clk), .rst_n(rst_n), .high_face(1'b0), .refl_pos(1'b1),
    .bound(low_z), .margin(margin_r),
    .dist_damp(dist_damp_r), .energy_damp(energy_damp_r),
    .ctl_in(ctl_s0_r), .pos_in(pos_z_s0_r), .vel_in(vel_z_s0_r),
    .ctl_out(ctl_z1), .pos_out(pos_z1), .vel_out(vel_z1)
  );

  pbbr_face #(.COORD_BITS(CB)) u_far (
    .clk(clk), .rst_n(rst_n), .high_face(1'b1), .refl_pos(1'b0),
    .bound(high_z), .margin(margin_r),
    .dist_damp(dist_damp_r), .energy_damp(energy_damp_r),
    .ctl_in(ctl_z1), .pos_in(pos_z1), .vel_in(vel_z1),
    .ctl_out(ctl_z2), .pos_out(pos_z2), .vel_out(vel_z2)
  );

  // All chains carry the same valid bits; the y chain's are used.
  assign out_valid     = ctl_y2.vld;
  assign out_collided  = ctl_y2.hit || ctl_x2.hit || ctl_z2.hit;
  assign out_new_pos_x = pos_x2;
  assign out_new_pos_y = pos_y2;
  assign out_new_pos_z = pos_z2;
  assign out_new_vel_x = vel_x2;
  assign out_new_vel_y = vel_y2;
  assign out_new_vel_z = vel_z2;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##7 out_valid)
    else $error("accepted particle did not produce a result after seven cycles");

  a_latency_back : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 7))
    else $error("result transfer without a matching accepted particle");

  a_clean_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_collided |->
      out_new_pos_x == $past(in_pos_x, 7) && out_new_pos_y == $past(in_pos_y, 7) &&
      out_new_pos_z == $past(in_pos_z, 7))
    else $error("position changed without a collision");

  a_clean_vel : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_collided |->
      out_new_vel_x == $past(in_vel_x, 7) && out_new_vel_y == $past(in_vel_y, 7) &&
      out_new_vel_z == $past(in_vel_z, 7))
    else $error("velocity changed without a collision");

endmodule

/* tb/tb_particle_box_boundary_response.sv */
// ============================================================================
// tb_particle_box_boundary_response: self-checking bench for the box boundary
// Feeds particles at random burst rates through several register setups,
// predicts every corrected particle in the bench and checks each result
// field by field in order of arrival.
// ============================================================================
module tb_particle_box_boundary_response
  import pbbr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = PBBR_COORD_BITS;
  localparam int MARGIN_BITS = 19;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  localparam longint COORD_MAX = (longint'(1) << (CB - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (CB - 1));
  localparam longint BOX_EDGE  = 65536;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [PBBR_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [PBBR_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic [CB-1:0] pz;
    logic [CB-1:0] vx;
    logic [CB-1:0] vy;
    logic [CB-1:0] vz;
  } particle_t;

  typedef struct packed {
    particle_t part;
    logic      collided;
  } response_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [CB-1:0]  in_pos_x = '0;
  logic signed [CB-1:0]  in_pos_y = '0;
  logic signed [CB-1:0]  in_pos_z = '0;
  logic signed [CB-1:0]  in_vel_x = '0;
  logic signed [CB-1:0]  in_vel_y = '0;
  logic signed [CB-1:0]  in_vel_z = '0;
  logic                  out_valid;
  logic signed [CB-1:0]  out_new_pos_x;
  logic signed [CB-1:0]  out_new_pos_y;
  logic signed [CB-1:0]  out_new_pos_z;
  logic signed [CB-1:0]  out_new_vel_x;
  logic signed [CB-1:0]  out_new_vel_y;
  logic signed [CB-1:0]  out_new_vel_z;
  logic                  out_collided;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PBBR_IDX_BITS-1:0] cfg_index;
  logic [3*CB-1:0]       cfg_data;

  // Bench copy of the register file.
  logic [3*CB-1:0]        box_lo       = '0;
  logic [3*CB-1:0]        box_hi       = '0;
  logic [MARGIN_BITS-1:0] margin_q     = MARGIN_BITS'(PBBR_MARGIN_RST);
  logic                   roof_is_open = 1'b0;
  logic [PBBR_DAMP_BITS-1:0] dist_damp   = '0;
  logic [PBBR_DAMP_BITS-1:0] energy_damp = PBBR_DAMP_BITS'(PBBR_ENERGY_DAMP_RST);

  particle_t particle_q [$];
  response_t corrected_q [$];

  logic took = 1'b0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_mismatch = 0;
  int   idle_cycles = 0;
  int   burst_left = 1;
  int   gap_left = 0;

  particle_box_boundary_response #(
    .COORD_BITS(CB)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_vel_z      (in_vel_z),
    .out_valid     (out_valid),
    .out_new_pos_x (out_new_pos_x),
    .out_new_pos_y (out_new_pos_y),
    .out_new_pos_z (out_new_pos_z),
    .out_new_vel_x (out_new_vel_x),
    .out_new_vel_y (out_new_vel_y),
    .out_new_vel_z (out_new_vel_z),
    .out_collided  (out_collided),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5ns clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint corner_axis(input logic [3*CB-1:0] corner, input int axis);
    logic signed [CB-1:0] field;
    field = corner[axis*CB +: CB];
    return longint'(field);
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Drops the Q0.16 fraction, rounding to nearest with ties upward.
  function automatic longint round_damp(input longint p);
    return (p + (longint'(1) << (PBBR_DAMP_BITS - 1))) >>> PBBR_DAMP_BITS;
  endfunction

  function automatic longint push_back(input longint pos, input longint depth);
    longint gain;
    gain = (longint'(1) << PBBR_DAMP_BITS) + longint'(dist_damp);
    return clamp_coord(pos - round_damp(depth * gain));
  endfunction

  function automatic longint reflect_vel(input longint vel);
    return clamp_coord(round_damp(-vel * longint'(energy_damp)));
  endfunction

  function automatic response_t resolve_particle(input particle_t pt);
    longint    p [3];
    longint    v [3];
    longint    lo [3];
    longint    hi [3];
    longint    d;
    longint    m;
    logic      hit;
    int        i;
    response_t r;
    p[0] = longint'($signed(pt.px));
    p[1] = longint'($signed(pt.py));
    p[2] = longint'($signed(pt.pz));
    v[0] = longint'($signed(pt.vx));
    v[1] = longint'($signed(pt.vy));
    v[2] = longint'($signed(pt.vz));
    for (i = 0; i < 3; i++) begin
      lo[i] = corner_axis(box_lo, i);
      hi[i] = corner_axis(box_hi, i);
    end
    m = longint'(margin_q);
    hit = 1'b0;

    // A particle above the roof that is not caught leaves untouched.
    d = p[1] - hi[1];
    if (d > 0) begin
      if (roof_is_open || d >= m) begin
        r.part = pt;
        r.collided = 1'b0;
        return r;
      end
      p[1] = push_back(p[1], d);
      if (v[1] > 0) v[1] = reflect_vel(v[1]);
      hit = 1'b1;
    end
    d = p[1] - lo[1];
    if (d < 0 && -d < m) begin
      p[1] = push_back(p[1], d);
      if (v[1] < 0) v[1] = reflect_vel(v[1]);
      hit = 1'b1;
    end
    d = p[0] - hi[0];
    if (d > 0 && d < m) begin
      p[0] = push_back(p[0], d);
      if (v[0] > 0) v[0] = reflect_vel(v[0]);
      hit = 1'b1;
    end
    d = p[0] - lo[0];
    if (d < 0 && -d < m) begin
      p[0] = push_back(p[0], d);
      if (v[0] < 0) v[0] = reflect_vel(v[0]);
      hit = 1'b1;
    end
    // The two z faces test the velocity sign the opposite way round.
    d = p[2] - lo[2];
    if (d < 0 && -d < m) begin
      p[2] = push_back(p[2], d);
      if (v[2] > 0) v[2] = reflect_vel(v[2]);
      hit = 1'b1;
    end
    d = p[2] - hi[2];
    if (d > 0 && d < m) begin
      p[2] = push_back(p[2], d);
      if (v[2] < 0) v[2] = reflect_vel(v[2]);
      hit = 1'b1;
    end

    r.part.px = CB'(p[0]);
    r.part.py = CB'(p[1]);
    r.part.pz = CB'(p[2]);
    r.part.vx = CB'(v[0]);
    r.part.vy = CB'(v[1]);
    r.part.vz = CB'(v[2]);
    r.collided = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [3*CB-1:0] pack_corner(input longint x, input longint y,
                                                  input longint z);
    return {CB'(z), CB'(y), CB'(x)};
  endfunction

  // Mostly lands within 1.5 margins plus two of one face of the current box.
  function automatic logic [CB-1:0] pick_coord(input int axis);
    longint face;
    longint span;
    longint off;
    face = $urandom_range(0, 1) ? corner_axis(box_hi, axis) : corner_axis(box_lo, axis);
    span = longint'(margin_q) + (longint'(margin_q) >> 1) + 2;
    case ($urandom_range(0, 9))
      0: off = longint'(margin_q);
      1: off = -longint'(margin_q);
      2: off = longint'(margin_q) - 1;
      3: off = 1 - longint'(margin_q);
      4: return CB'($urandom);
      default: off = longint'($urandom_range(0, 32'(2 * span))) - span;
    endcase
    return CB'(clamp_coord(face + off));
  endfunction

  function automatic logic [CB-1:0] pick_velocity();
    case ($urandom_range(0, 5))
      0: return CB'(COORD_MIN);
      1: return CB'(COORD_MAX);
      2: return CB'(longint'($urandom_range(0, 16384)) - 8192);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic queue_particle(input longint px, input longint py, input longint pz,
                                input longint vx, input longint vy, input longint vz);
    particle_t pt;
    pt = '{px: CB'(px), py: CB'(py), pz: CB'(pz), vx: CB'(vx), vy: CB'(vy), vz: CB'(vz)};
    particle_q.push_back(pt);
    n_sent++;
  endtask

  task automatic queue_random(input int count);
    particle_t pt;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        pt.px = CB'($urandom);
        pt.py = CB'($urandom);
        pt.pz = CB'($urandom);
      end else begin
        pt.px = pick_coord(0);
        pt.py = pick_coord(1);
        pt.pz = pick_coord(2);
      end
      pt.vx = pick_velocity();
      pt.vy = pick_velocity();
      pt.vz = pick_velocity();
      particle_q.push_back(pt);
      n_sent++;
    end
  endtask

  task automatic wait_until_drained();
    while (n_checked != n_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [PBBR_IDX_BITS-1:0] idx,
                                input logic [3*CB-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      PBBR_REG_LOW_CORNER:  box_lo = data;
      PBBR_REG_HIGH_CORNER: box_hi = data;
      PBBR_REG_MARGIN:      margin_q = data[MARGIN_BITS-1:0];
      PBBR_REG_ROOF_OPEN:   roof_is_open = data[0];
      PBBR_REG_DIST_DAMP:   dist_damp = data[PBBR_DAMP_BITS-1:0];
      PBBR_REG_ENERGY_DAMP: energy_damp = data[PBBR_DAMP_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_setup(input logic [3*CB-1:0] lo, input logic [3*CB-1:0] hi,
                             input logic [MARGIN_BITS-1:0] m, input logic roof,
                             input logic [PBBR_DAMP_BITS-1:0] dd,
                             input logic [PBBR_DAMP_BITS-1:0] ed);
    write_register(PBBR_REG_LOW_CORNER, lo);
    write_register(PBBR_REG_HIGH_CORNER, hi);
    write_register(PBBR_REG_MARGIN, (3*CB)'(m));
    write_register(PBBR_REG_ROOF_OPEN, (3*CB)'(roof));
    write_register(PBBR_REG_DIST_DAMP, (3*CB)'(dd));
    write_register(PBBR_REG_ENERGY_DAMP, (3*CB)'(ed));
  endtask

  task automatic write_random_setup();
    logic [3*CB-1:0]           lo;
    logic [3*CB-1:0]           hi;
    logic [MARGIN_BITS-1:0]    m;
    logic [PBBR_DAMP_BITS-1:0] dd;
    logic [PBBR_DAMP_BITS-1:0] ed;
    longint                    a;
    longint                    b;
    int                        axis;
    for (axis = 0; axis < 3; axis++) begin
      case ($urandom_range(0, 5))
        0: begin a = COORD_MIN; b = COORD_MAX; end
        1: begin
          a = corner_axis((3*CB)'($urandom), 0);
          b = corner_axis((3*CB)'($urandom), 0);
        end
        default: begin
          a = -longint'($urandom_range(0, 300000));
          b = longint'($urandom_range(0, 300000));
        end
      endcase
      lo[axis*CB +: CB] = CB'(a);
      hi[axis*CB +: CB] = CB'(b);
    end
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = '1;
      2: m = MARGIN_BITS'($urandom);
      default: m = MARGIN_BITS'($urandom_range(1, 32768));
    endcase
    case ($urandom_range(0, 3))
      0: dd = '0;
      1: dd = '1;
      default: dd = PBBR_DAMP_BITS'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: ed = '0;
      1: ed = '1;
      default: ed = PBBR_DAMP_BITS'($urandom);
    endcase
    write_setup(lo, hi, m, $urandom_range(0, 3) == 0, dd, ed);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : feed_particles
    particle_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (particle_q.size() != 0) begin
        nxt = particle_q.pop_front();
        in_pos_x <= nxt.px;
        in_pos_y <= nxt.py;
        in_pos_z <= nxt.pz;
        in_vel_x <= nxt.vx;
        in_vel_y <= nxt.vy;
        in_vel_z <= nxt.vz;
        start <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          case ($urandom_range(0, 7))
            0, 1: begin burst_left = $urandom_range(20, 80); gap_left = 0; end
            2: begin burst_left = $urandom_range(1, 4); gap_left = $urandom_range(20, 30); end
            3: begin burst_left = $urandom_range(1, 3); gap_left = $urandom_range(1, 3); end
            default: begin
              burst_left = $urandom_range(1, 12);
              gap_left = $urandom_range(0, 8);
            end
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic flag_mismatch(input string what, input logic [CB-1:0] want,
                               input logic [CB-1:0] got);
    n_mismatch++;
    if (n_mismatch <= REPORT_MAX)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : check_and_predict
    response_t want;
    particle_t seen;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_valid) begin
        if (corrected_q.size() == 0) begin
          flag_mismatch("result with nothing pending", '0, '0);
        end else begin
          want = corrected_q.pop_front();
          if (out_new_pos_x !== want.part.px)
            flag_mismatch("new_pos_x", want.part.px, out_new_pos_x);
          if (out_new_pos_y !== want.part.py)
            flag_mismatch("new_pos_y", want.part.py, out_new_pos_y);
          if (out_new_pos_z !== want.part.pz)
            flag_mismatch("new_pos_z", want.part.pz, out_new_pos_z);
          if (out_new_vel_x !== want.part.vx)
            flag_mismatch("new_vel_x", want.part.vx, out_new_vel_x);
          if (out_new_vel_y !== want.part.vy)
            flag_mismatch("new_vel_y", want.part.vy, out_new_vel_y);
          if (out_new_vel_z !== want.part.vz)
            flag_mismatch("new_vel_z", want.part.vz, out_new_vel_z);
          if (out_collided !== want.collided)
            flag_mismatch("collided", CB'(want.collided), CB'(out_collided));
          n_checked <= n_checked + 1;
        end
      end
      took <= start && !busy;
      if (start && !busy) begin
        seen.px = in_pos_x;
        seen.py = in_pos_y;
        seen.pz = in_pos_z;
        seen.vx = in_vel_x;
        seen.vy = in_vel_y;
        seen.vz = in_vel_z;
        corrected_q.push_back(resolve_particle(seen));
      end
    end
  end

  // The run is declared hung when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = PBBR_REG_LOW_CORNER;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register values straight out of reset.
    queue_random(80);
    wait_until_drained();

    write_setup(pack_corner(-BOX_EDGE, -BOX_EDGE, -BOX_EDGE),
                pack_corner(BOX_EDGE, BOX_EDGE, BOX_EDGE), MARGIN_BITS'(8192), 1'b0,
                PBBR_DAMP_BITS'(16384), PBBR_DAMP_BITS'(49152));
    queue_particle(0, 0, 0, 100, -100, 50);
    queue_particle(0, BOX_EDGE + 1000, 0, 0, 4096, 0);
    queue_particle(0, BOX_EDGE + 1000, 0, 0, -4096, 0);
    // Above the roof by exactly the margin: passes through, x face ignored.
    queue_particle(BOX_EDGE + 100, BOX_EDGE + 8192, 0, 5, 5, 5);
    queue_particle(BOX_EDGE + 100, COORD_MAX, -BOX_EDGE - 100, -1, -1, -1);
    queue_particle(0, -BOX_EDGE - 500, 0, 0, -300, 0);
    queue_particle(0, -BOX_EDGE - 8192, 0, 0, -300, 0);
    queue_particle(0, -BOX_EDGE - 8191, 0, 0, -300, 0);
    queue_particle(BOX_EDGE + 1, 0, 0, COORD_MAX, 0, 0);
    queue_particle(-BOX_EDGE - 8191, 0, 0, COORD_MIN, 0, 0);
    queue_particle(0, 0, -BOX_EDGE - 2000, 0, 0, 5000);
    queue_particle(0, 0, -BOX_EDGE - 2000, 0, 0, -5000);
    queue_particle(0, 0, BOX_EDGE + 2000, 0, 0, -5000);
    queue_particle(0, 0, BOX_EDGE + 2000, 0, 0, 5000);
    queue_particle(BOX_EDGE + 300, -BOX_EDGE - 300, BOX_EDGE + 300, 777, -777, -777);
    queue_particle(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_particle(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_particle(BOX_EDGE, -BOX_EDGE, BOX_EDGE, 1, -1, 1);
    queue_particle(-BOX_EDGE, BOX_EDGE, -BOX_EDGE, -1, 1, -1);
    queue_particle(BOX_EDGE + 7000, BOX_EDGE + 7000, -BOX_EDGE - 7000,
                   300000, 300000, 300000);
    queue_random(100);
    wait_until_drained();

    write_register(PBBR_REG_ROOF_OPEN, (3*CB)'(1));
    queue_particle(0, BOX_EDGE + 10, 0, 0, 1, 0);
    queue_particle(BOX_EDGE + 10, BOX_EDGE + 10, BOX_EDGE + 10, 1, 1, -1);
    queue_random(60);
    wait_until_drained();

    write_register(PBBR_REG_MARGIN, '0);
    queue_particle(BOX_EDGE + 1, -BOX_EDGE - 1, BOX_EDGE + 1, 9, -9, -9);
    queue_random(40);
    wait_until_drained();

    // Spare indexes hold no register; the next items check that nothing moved.
    write_register(REG_SPARE_LO, (3*CB)'({$urandom, $urandom}));
    write_register(REG_SPARE_HI, '1);
    queue_random(20);
    wait_until_drained();

    write_setup(pack_corner(COORD_MIN, COORD_MIN, COORD_MIN),
                pack_corner(COORD_MAX, COORD_MAX, COORD_MAX), '1, 1'b0, '1, '1);
    queue_random(60);
    wait_until_drained();

    // Inverted box with the smallest nonzero margin.
    write_setup(pack_corner(COORD_MAX, COORD_MAX, COORD_MAX),
                pack_corner(COORD_MIN, COORD_MIN, COORD_MIN), MARGIN_BITS'(1), 1'b0,
                '0, '0);
    queue_random(60);
    wait_until_drained();

    repeat (6) begin
      write_random_setup();
      queue_random(110);
      wait_until_drained();
    end

    repeat (20) @(posedge clk);
    if (n_mismatch == 0 && corrected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
